// ===== rtl/core/sfb_pkg.sv =====
package sfb_pkg;

	localparam int MAX_BEATS  = 9;
	localparam int BEAT_IDX_W = 4;

	localparam logic [7:0] SYNC_FIRST  = 8'h5A;
	localparam logic [7:0] SYNC_SECOND = 8'hA5;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_PAYLOAD = 1'b1;

	localparam logic [BEAT_IDX_W-1:0] BEATS_HDR      = 4'd7;
	localparam logic [BEAT_IDX_W-1:0] BEATS_HDR_CS   = 4'd9;
	localparam logic [BEAT_IDX_W-1:0] BEATS_DATA     = 4'd1;
	localparam logic [BEAT_IDX_W-1:0] BEATS_DATA_CS  = 4'd3;

	// One accepted item's worth of output beats, sent from index 0 upward
	typedef struct packed {
		logic [MAX_BEATS-1:0][7:0]  bytes;
		logic [BEAT_IDX_W-1:0]      count;
		logic                       ends;
	} burst_t;

endpackage

// ===== rtl/core/sfb_framer.sv =====
module sfb_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                action,
	input  logic [7:0]          source_id,
	input  logic [7:0]          dest_id,
	input  logic [7:0]          payload_len,
	input  logic [7:0]          command,
	input  logic [7:0]          index_byte,
	input  logic [7:0]          payload_byte,
	output logic                burst_valid,
	output sfb_pkg::burst_t     burst
);

	logic [15:0] sum_q;
	logic [7:0]  left_q;
	logic        open_q;

	logic [15:0] sum_d;
	logic [7:0]  left_d;
	logic        open_d;
	logic [15:0] hdr_sum;
	logic [15:0] data_sum;
	logic [15:0] cs;
	logic        last_data;

	always_comb begin
		hdr_sum = {8'd0, payload_len} + {8'd0, source_id} + {8'd0, dest_id}
			+ {8'd0, command} + {8'd0, index_byte};
		data_sum  = sum_q + {8'd0, payload_byte};
		last_data = (left_q == 8'd1);
		burst       = '0;
		burst_valid = 1'b0;
		sum_d  = sum_q;
		left_d = left_q;
		open_d = open_q;
		cs     = '0;
		if (action == sfb_pkg::ACT_START) begin
			cs = ~hdr_sum;
			burst_valid    = 1'b1;
			burst.bytes[0] = sfb_pkg::SYNC_FIRST;
			burst.bytes[1] = sfb_pkg::SYNC_SECOND;
			burst.bytes[2] = payload_len;
			burst.bytes[3] = source_id;
			burst.bytes[4] = dest_id;
			burst.bytes[5] = command;
			burst.bytes[6] = index_byte;
			burst.bytes[7] = cs[7:0];
			burst.bytes[8] = cs[15:8];
			burst.ends     = (payload_len == 8'd0);
			burst.count    = burst.ends ? sfb_pkg::BEATS_HDR_CS : sfb_pkg::BEATS_HDR;
			sum_d  = hdr_sum;
			left_d = payload_len;
			open_d = (payload_len != 8'd0);
		end else if (open_q && left_q != 8'd0) begin
			cs = ~data_sum;
			burst_valid    = 1'b1;
			burst.bytes[0] = payload_byte;
			burst.bytes[1] = cs[7:0];
			burst.bytes[2] = cs[15:8];
			burst.ends     = last_data;
			burst.count    = last_data ? sfb_pkg::BEATS_DATA_CS : sfb_pkg::BEATS_DATA;
			sum_d  = data_sum;
			left_d = left_q - 8'd1;
			open_d = !last_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			left_q <= '0;
			open_q <= 1'b0;
		end else if (accept) begin
			sum_q  <= sum_d;
			left_q <= left_d;
			open_q <= open_d;
		end
	end

	a_open_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> left_q != 8'd0)
		else $error("open frame with no bytes left");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == sfb_pkg::ACT_START && payload_len != 8'd0
		|=> open_q && left_q == $past(payload_len))
		else $error("start did not open frame");

endmodule

// ===== rtl/core/sfb_emitter.sv =====
module sfb_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                burst_valid,
	input  sfb_pkg::burst_t     burst,
	output logic                ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);

	sfb_pkg::burst_t                     burst_s1;
	logic                                valid_s1;
	logic [sfb_pkg::BEAT_IDX_W-1:0]      idx_q;
	logic                                last_beat;
	logic                                beat;

	assign last_beat = (idx_q == burst_s1.count - 4'd1);
	assign beat      = valid_s1 && m_tready;
	assign ready     = !valid_s1 || (m_tready && last_beat);

	assign m_tvalid = valid_s1;
	assign m_tdata  = burst_s1.bytes[idx_q];
	assign m_tlast  = valid_s1 && last_beat && burst_s1.ends;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (accept) begin
			// load next burst; a dropped beat just empties the stage
			valid_s1 <= burst_valid;
			idx_q    <= '0;
		end else if (beat) begin
			if (last_beat) begin
				valid_s1 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && burst_valid) begin
			burst_s1 <= burst;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_q < burst_s1.count)
		else $error("beat index past burst");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tready && !last_beat |=> valid_s1 && idx_q == $past(idx_q) + 4'd1)
		else $error("burst did not advance");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !m_tready |-> !ready)
		else $error("ready while stalled burst");

endmodule

// ===== rtl/core/serial_frame_builder.sv =====
// Serial frame builder.
// Input stream (s_*): one beat per item. s_tuser is the action: 0 starts a
// frame from the header fields in s_tdata, 1 carries one payload byte.
// Output stream (m_*): one frame byte per beat; m_tlast marks the high
// checksum byte that closes a frame.
// A start beat gives 7 output beats (sync, sync, length, source, dest,
// command, index), or 9 when the length is zero and the checksum follows.
// A payload beat gives 1 output beat, or 3 on the last byte of a frame.
// Payload with no open frame is taken and dropped; a start abandons any
// open frame without a checksum.
// Latency: the first output beat is valid the cycle after the input beat.
// Throughput: one input beat per cycle while each gives one output beat and
// m_tready stays high; s_tready is low while the output stage still has beats
// of the previous item to send, so a start holds the input until they are sent.
// When m_tready is low the current beat is held and s_tready drops.
// Reset clears the frame state and empties the output stage.
module serial_frame_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] source_id, [15:8] dest_id, [23:16] payload_len,
	// [31:24] command, [39:32] index_byte, [47:40] payload_byte
	input  logic [47:0] s_tdata,
	// [0] action
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	// frame_end
	output logic        m_tlast
);

	logic            accept;
	logic            burst_valid;
	sfb_pkg::burst_t burst;

	assign accept = s_tvalid && s_tready;

	sfb_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (s_tuser),
		.source_id    (s_tdata[7:0]),
		.dest_id      (s_tdata[15:8]),
		.payload_len  (s_tdata[23:16]),
		.command      (s_tdata[31:24]),
		.index_byte   (s_tdata[39:32]),
		.payload_byte (s_tdata[47:40]),
		.burst_valid  (burst_valid),
		.burst        (burst)
	);

	sfb_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.burst_valid (burst_valid),
		.burst       (burst),
		.ready       (s_tready),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

// ===== test/serial_frame_builder_test.sv =====
module serial_frame_builder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int RANDOM_ITEMS  = 60;
	localparam int LONG_LEN      = 100;
	localparam int GAP_PERCENT   = 13;

	typedef struct packed {
		logic       action;
		logic [7:0] source_id;
		logic [7:0] dest_id;
		logic [7:0] payload_len;
		logic [7:0] command;
		logic [7:0] index_byte;
		logic [7:0] payload_byte;
	} frame_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// frame state mirrored from the accepted beats
	logic [15:0] frame_sum;
	logic [7:0]  frame_left;
	logic        frame_active;

	frame_byte_t tx_expected[$];
	frame_byte_t tx_head;
	int          errors = 0;
	int          idle_cycles = 0;
	bit          src_gaps = 1'b1;
	bit          sink_gaps = 1'b1;

	serial_frame_builder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void emit_expected(input logic [7:0] b, input logic last);
		frame_byte_t fb;
		fb.data = b;
		fb.last = last;
		tx_expected.push_back(fb);
	endfunction

	function automatic void emit_summed(input logic [7:0] b);
		frame_sum = frame_sum + 16'(b);
		emit_expected(b, 1'b0);
	endfunction

	function automatic void emit_checksum();
		logic [15:0] cs;
		cs = ~frame_sum;
		emit_expected(cs[7:0], 1'b0);
		emit_expected(cs[15:8], 1'b1);
		frame_active = 1'b0;
		frame_left = '0;
	endfunction

	function automatic void predict_tx(input frame_item_t it);
		if (it.action == sfb_pkg::ACT_START) begin
			frame_sum = '0;
			emit_expected(sfb_pkg::SYNC_FIRST, 1'b0);
			emit_expected(sfb_pkg::SYNC_SECOND, 1'b0);
			emit_summed(it.payload_len);
			emit_summed(it.source_id);
			emit_summed(it.dest_id);
			emit_summed(it.command);
			emit_summed(it.index_byte);
			if (it.payload_len == 8'd0) begin
				emit_checksum();
			end else begin
				frame_left = it.payload_len;
				frame_active = 1'b1;
			end
		end else if (frame_active && frame_left != 8'd0) begin
			emit_summed(it.payload_byte);
			frame_left = frame_left - 8'd1;
			if (frame_left == 8'd0) begin
				emit_checksum();
			end
		end
		// otherwise the payload beat is dropped
	endfunction

	function automatic frame_item_t rand_item(input logic act);
		frame_item_t it;
		it.action       = act;
		it.source_id    = 8'($urandom_range(255));
		it.dest_id      = 8'($urandom_range(255));
		it.payload_len  = 8'($urandom_range(255));
		it.command      = 8'($urandom_range(255));
		it.index_byte   = 8'($urandom_range(255));
		it.payload_byte = 8'($urandom_range(255));
		return it;
	endfunction

	function automatic frame_item_t start_item(input logic [7:0] len, input logic [7:0] fill);
		frame_item_t it;
		it.action       = sfb_pkg::ACT_START;
		it.source_id    = fill;
		it.dest_id      = fill;
		it.payload_len  = len;
		it.command      = fill;
		it.index_byte   = fill;
		it.payload_byte = fill;
		return it;
	endfunction

	function automatic frame_item_t payload_item(input logic [7:0] b);
		frame_item_t it;
		it = start_item(8'd0, ~b);
		it.action = sfb_pkg::ACT_PAYLOAD;
		it.payload_byte = b;
		return it;
	endfunction

	task automatic send_item(input frame_item_t it);
		while (src_gaps && $urandom_range(99) < GAP_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.action;
		s_tdata  <= {it.payload_byte, it.index_byte, it.command,
			it.payload_len, it.dest_id, it.source_id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tx(it);
	endtask

	task automatic test_orphan_payload();
		send_item(payload_item(8'h00));
		send_item(payload_item(8'hFF));
	endtask

	task automatic test_zero_length();
		send_item(start_item(8'd0, 8'h00));
		send_item(start_item(8'd0, 8'hFF));
		// nothing is open after a zero-length frame
		send_item(payload_item(8'h3C));
	endtask

	task automatic test_short_frames();
		send_item(start_item(8'd1, 8'h00));
		send_item(payload_item(8'hFF));
		send_item(start_item(8'd2, 8'hA5));
		send_item(payload_item(8'h00));
		send_item(payload_item(8'hFF));
		send_item(payload_item(8'h81));
	endtask

	task automatic test_abandon();
		send_item(start_item(8'd255, 8'hFF));
		send_item(payload_item(8'h12));
		send_item(payload_item(8'hED));
		send_item(payload_item(8'h7F));
		send_item(start_item(8'd1, 8'h5A));
		send_item(payload_item(8'h80));
		send_item(start_item(8'd3, 8'h01));
		send_item(start_item(8'd0, 8'hFE));
	endtask

	task automatic test_long_frame();
		// run one long all-ones frame with no idling on either side
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		send_item(start_item(8'(LONG_LEN), 8'hFF));
		for (int i = 0; i < LONG_LEN; i++) begin
			send_item(payload_item(8'hFF));
		end
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		frame_item_t it;
		int          sent;
		int          roll;
		int          n_payload;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 10) begin
				send_item(rand_item(sfb_pkg::ACT_PAYLOAD));
				sent++;
			end else begin
				it = rand_item(sfb_pkg::ACT_START);
				roll = $urandom_range(99);
				if (roll < 15)
					it.payload_len = 8'd0;
				else if (roll < 75)
					it.payload_len = 8'($urandom_range(6, 1));
				else if (roll < 95)
					it.payload_len = 8'($urandom_range(30, 7));
				else
					it.payload_len = 8'($urandom_range(255, 31));
				roll = $urandom_range(99);
				if (roll < 80)
					n_payload = it.payload_len;
				else if (roll < 90)
					n_payload = (it.payload_len == 0) ? 0 : $urandom_range(it.payload_len - 1);
				else
					n_payload = it.payload_len + $urandom_range(3, 1);
				send_item(it);
				sent++;
				for (int j = 0; j < n_payload && sent < RANDOM_ITEMS; j++) begin
					send_item(rand_item(sfb_pkg::ACT_PAYLOAD));
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		m_tready <= !(sink_gaps && $urandom_range(99) < GAP_PERCENT);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tx_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat data %h last %b", $time, m_tdata, m_tlast);
			end else begin
				tx_head = tx_expected.pop_front();
				if (m_tdata !== tx_head.data) begin
					errors++;
					$display("%0t: out_byte expected %h actual %h",
						$time, tx_head.data, m_tdata);
				end
				if (m_tlast !== tx_head.last) begin
					errors++;
					$display("%0t: frame_end expected %b actual %b",
						$time, tx_head.last, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		frame_sum    = '0;
		frame_left   = '0;
		frame_active = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_orphan_payload();
		test_zero_length();
		test_short_frames();
		test_abandon();
		test_long_frame();
		test_random_traffic();

		s_tvalid <= 1'b0;
		while (tx_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sfb_pkg.sv
rtl/core/sfb_framer.sv
rtl/core/sfb_emitter.sv
rtl/core/serial_frame_builder.sv
test/serial_frame_builder_test.sv
